// ===== rtl/slot_task_pool_unit_macros.svh =====
// assertion macros used by slot_task_pool_unit
`ifndef SLOT_TASK_POOL_UNIT_MACROS_SVH
`define SLOT_TASK_POOL_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define SPU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define SPU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SPU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define SPU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/spu_pkg.sv =====
`timescale 1ns / 1ps
package spu_pkg;

  // defaults for the top level parameters
  localparam int unsigned SLOTS_DEF       = 64;
  localparam int unsigned HANDLE_BITS_DEF = 32;

  // widest slot index the chain carries (up to 4096 slots)
  localparam int unsigned IDX_MAX_W = 12;
  localparam int unsigned RND_W     = 16;
  localparam int unsigned OP_W      = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_TAKE   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // search wave moving along the chain of slot cells
  typedef struct packed {
    logic                 vld;
    logic [IDX_MAX_W-1:0] start;
    logic                 free_fnd;
    logic [IDX_MAX_W-1:0] free_idx;
    logic                 occ_fnd;
    logic [IDX_MAX_W-1:0] occ_idx;
    logic                 last_fnd;
    logic [IDX_MAX_W-1:0] last_idx;
  } wave_t;

  // valid bit update broadcast to every cell
  typedef struct packed {
    logic                 clr_all;
    logic                 set;
    logic                 clr;
    logic [IDX_MAX_W-1:0] idx;
  } upd_t;

endpackage

// ===== rtl/spu_ram.sv =====
`timescale 1ns / 1ps
module spu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/spu_cell.sv =====
`timescale 1ns / 1ps
module spu_cell import spu_pkg::*; #(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  wave_t wave_i,
  input  upd_t  upd_i,
  output wave_t wave_o,
  output logic  valid_o
);

  localparam logic [IDX_MAX_W-1:0] MY_IDX = IDX_MAX_W'(CELL_IDX);

  logic  valid_q, valid_d;
  wave_t wave_q, wave_d;

  // fold this slot into the passing search wave
  always_comb begin
    wave_d = wave_i;
    if (!wave_i.free_fnd && !valid_q) begin
      wave_d.free_fnd = 1'b1;
      wave_d.free_idx = MY_IDX;
    end
    if (!wave_i.occ_fnd && valid_q && (MY_IDX >= wave_i.start)) begin
      wave_d.occ_fnd = 1'b1;
      wave_d.occ_idx = MY_IDX;
    end
    if (valid_q) begin
      wave_d.last_fnd = 1'b1;
      wave_d.last_idx = MY_IDX;
    end
  end

  // occupancy bit of this slot
  always_comb begin
    valid_d = valid_q;
    if (upd_i.clr_all) begin
      valid_d = 1'b0;
    end else if (upd_i.set && (upd_i.idx == MY_IDX)) begin
      valid_d = 1'b1;
    end else if (upd_i.clr && (upd_i.idx == MY_IDX)) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      wave_q  <= '0;
    end else begin
      valid_q <= valid_d;
      wave_q  <= wave_d;
    end
  end

  assign wave_o  = wave_q;
  assign valid_o = valid_q;

endmodule

// ===== rtl/slot_task_pool_unit.sv =====
// an insert walks the slot chain once, a deterministic or slot-0 take walks it once
//   and then reads the handle, a randomized take walks it twice; clear and no-op skip it
// throughput: one operation at a time; the search wave walks the slot chain
//   one cell per cycle, twice for a randomized take
// reset clears every slot valid bit, the occupancy count, the mode register
//   and the output valid flag at once; handle storage is not cleared
`timescale 1ns / 1ps
`include "slot_task_pool_unit_macros.svh"
module slot_task_pool_unit import spu_pkg::*; #(
  parameter int unsigned SLOTS       = SLOTS_DEF,
  parameter int unsigned HANDLE_BITS = HANDLE_BITS_DEF,
  localparam int unsigned IDX_W = $clog2(SLOTS),
  localparam int unsigned CNT_W = $clog2(SLOTS + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [OP_W-1:0]        operation_i,
  input  logic [HANDLE_BITS-1:0] task_handle_i,
  input  logic [RND_W-1:0]       random_value_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   success_o,
  output logic [HANDLE_BITS-1:0] handle_out_o,
  output logic [IDX_W-1:0]       slot_index_o,
  output logic [CNT_W-1:0]       occupancy_o
);

  localparam int unsigned PROD_W = RND_W + IDX_W;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SCAN1   = 3'd1;
  localparam logic [2:0] ST_LAUNCH2 = 3'd2;
  localparam logic [2:0] ST_SCAN2   = 3'd3;
  localparam logic [2:0] ST_READ    = 3'd4;
  localparam logic [2:0] ST_RDATA   = 3'd5;
  localparam logic [2:0] ST_DONE    = 3'd6;

  logic [2:0]             state_q, state_d;
  logic                   det_q;
  logic [OP_W-1:0]        op_q, op_d;
  logic [HANDLE_BITS-1:0] handle_q, handle_d;
  logic [RND_W-1:0]       rnd_q, rnd_d;
  logic [CNT_W-1:0]       occ_q, occ_d;
  logic [IDX_W-1:0]       lowest_q, lowest_d;
  logic [IDX_W-1:0]       pick_q, pick_d;
  logic [PROD_W-1:0]      prod_q, prod_d;
  logic                   res_success_q, res_success_d;
  logic [HANDLE_BITS-1:0] res_handle_q, res_handle_d;
  logic [IDX_W-1:0]       res_slot_q, res_slot_d;
  logic                   out_valid_q, out_valid_d;
  logic                   out_success_q;
  logic [HANDLE_BITS-1:0] out_handle_q;
  logic [IDX_W-1:0]       out_slot_q;
  logic [CNT_W-1:0]       out_occ_q;
  logic                   out_load;

  wave_t                  wave [SLOTS+1];
  wave_t                  wave_in;
  wave_t                  wave_out;
  upd_t                   upd;
  logic [SLOTS-1:0]       valid_vec;
  logic                   ram_we;
  logic                   ram_re;
  logic [HANDLE_BITS-1:0] ram_rdata;
  logic                   in_beat;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_beat    = in_valid_i && in_ready_o;
  assign wave_out   = wave[SLOTS];
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  // chain of slot cells
  assign wave[0] = wave_in;
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    spu_cell #(
      .CELL_IDX(g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .wave_i (wave[g]),
      .upd_i  (upd),
      .wave_o (wave[g+1]),
      .valid_o(valid_vec[g])
    );
  end

  // handle storage
  spu_ram #(
    .WIDTH(HANDLE_BITS),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(IDX_W'(wave_out.free_idx)),
    .wdata_i(handle_q),
    .re_i   (ram_re),
    .raddr_i(pick_q),
    .rdata_o(ram_rdata)
  );

  // sequencer
  always_comb begin
    state_d       = state_q;
    op_d          = op_q;
    handle_d      = handle_q;
    rnd_d         = rnd_q;
    occ_d         = occ_q;
    lowest_d      = lowest_q;
    pick_d        = pick_q;
    prod_d        = prod_q;
    res_success_d = res_success_q;
    res_handle_d  = res_handle_q;
    res_slot_d    = res_slot_q;
    wave_in       = '0;
    upd           = '0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          op_d          = operation_i;
          handle_d      = task_handle_i;
          rnd_d         = random_value_i;
          res_success_d = 1'b0;
          res_handle_d  = '0;
          res_slot_d    = '0;
          case (operation_i)
            OP_INSERT, OP_TAKE: begin
              wave_in.vld = 1'b1;
              state_d     = ST_SCAN1;
            end
            OP_CLEAR: begin
              upd.clr_all = 1'b1;
              occ_d       = '0;
              state_d     = ST_DONE;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_SCAN1: begin
        if (wave_out.vld) begin
          if (op_q == OP_INSERT) begin
            state_d = ST_DONE;
            if (wave_out.free_fnd) begin
              upd.set       = 1'b1;
              upd.idx       = wave_out.free_idx;
              ram_we        = 1'b1;
              occ_d         = occ_q + CNT_W'(1);
              res_success_d = 1'b1;
              res_slot_d    = IDX_W'(wave_out.free_idx);
            end
          end else if (!wave_out.occ_fnd) begin
            state_d = ST_DONE;
          end else if (det_q || (wave_out.occ_idx == '0)) begin
            pick_d  = IDX_W'(wave_out.occ_idx);
            state_d = ST_READ;
          end else begin
            // scaled start point below the highest occupied slot
            lowest_d = IDX_W'(wave_out.occ_idx);
            prod_d   = PROD_W'(rnd_q) * PROD_W'(IDX_W'(wave_out.last_idx));
            state_d  = ST_LAUNCH2;
          end
        end
      end
      ST_LAUNCH2: begin
        wave_in.vld   = 1'b1;
        wave_in.start = IDX_MAX_W'(prod_q[RND_W +: IDX_W]);
        state_d       = ST_SCAN2;
      end
      ST_SCAN2: begin
        if (wave_out.vld) begin
          pick_d  = wave_out.occ_fnd ? IDX_W'(wave_out.occ_idx) : lowest_q;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        ram_re  = 1'b1;
        upd.clr = 1'b1;
        upd.idx = IDX_MAX_W'(pick_q);
        occ_d   = occ_q - CNT_W'(1);
        state_d = ST_RDATA;
      end
      ST_RDATA: begin
        res_success_d = 1'b1;
        res_handle_d  = ram_rdata;
        res_slot_d    = pick_q;
        state_d       = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output beat register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      det_q       <= 1'b0;
      op_q        <= OP_INSERT;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        det_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    handle_q      <= handle_d;
    rnd_q         <= rnd_d;
    lowest_q      <= lowest_d;
    pick_q        <= pick_d;
    prod_q        <= prod_d;
    res_success_q <= res_success_d;
    res_handle_q  <= res_handle_d;
    res_slot_q    <= res_slot_d;
    if (out_load) begin
      out_success_q <= res_success_q;
      out_handle_q  <= res_handle_q;
      out_slot_q    <= res_slot_q;
      out_occ_q     <= occ_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign success_o    = out_success_q;
  assign handle_out_o = out_handle_q;
  assign slot_index_o = out_slot_q;
  assign occupancy_o  = out_occ_q;

  // checks
  `SPU_ASSERT_NOW(a_occ_matches_bits, clk_i, rst_ni, 1'b1,
    $countones(valid_vec) == 32'(occ_q), "occupancy count differs from valid bits")
  `SPU_ASSERT_NOW(a_wave_only_in_scan, clk_i, rst_ni, wave_out.vld,
    (state_q == ST_SCAN1) || (state_q == ST_SCAN2), "search wave outside a scan")
  `SPU_ASSERT_NEXT(a_out_drains, clk_i, rst_ni,
    out_valid_q && out_ready_i && !out_load, !out_valid_q, "output beat not released")
  `SPU_ASSERT_NOW(a_read_hits_valid, clk_i, rst_ni, state_q == ST_READ,
    valid_vec[pick_q], "take reads an empty slot")

endmodule

// ===== sim/slot_task_pool_unit_tb.sv =====
`timescale 1ns / 1ps
module slot_task_pool_unit_tb import spu_pkg::*;;

  localparam int unsigned SLOTS = 64;
  localparam int unsigned HB    = 32;
  localparam int unsigned IDX_W = 6;
  localparam int unsigned CNT_W = 7;

  // operation code three does nothing
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  // random phase flavors
  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_kind_e;

  typedef struct packed {
    logic             success;
    logic [HB-1:0]    handle;
    logic [IDX_W-1:0] slot;
    logic [CNT_W-1:0] occ;
  } pool_result_t;

  typedef struct packed {
    logic             mode;
    logic [OP_W-1:0]  op;
    logic [HB-1:0]    handle;
    logic [RND_W-1:0] rnd;
    logic             typed;
    pool_result_t     want;
  } dir_row_t;

  localparam int unsigned DIR_N = 22;

  // directed beats: mode, op, handle, random value, typed flag, typed result
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{1'b0, OP_TAKE,   32'h0000_0000, 16'h0000, 1'b1, '{1'b0, 32'h0, 6'd0, 7'd0}},
    '{1'b0, OP_NONE,   32'hdead_beef, 16'h1234, 1'b1, '{1'b0, 32'h0, 6'd0, 7'd0}},
    '{1'b0, OP_INSERT, 32'h0000_0000, 16'h0000, 1'b1, '{1'b1, 32'h0, 6'd0, 7'd1}},
    '{1'b0, OP_INSERT, 32'hffff_ffff, 16'hffff, 1'b1, '{1'b1, 32'h0, 6'd1, 7'd2}},
    '{1'b0, OP_INSERT, 32'h1234_5678, 16'h0000, 1'b1, '{1'b1, 32'h0, 6'd2, 7'd3}},
    '{1'b0, OP_INSERT, 32'h9abc_def0, 16'h0000, 1'b1, '{1'b1, 32'h0, 6'd3, 7'd4}},
    '{1'b0, OP_TAKE,   32'h5555_5555, 16'hffff, 1'b1, '{1'b1, 32'h0, 6'd0, 7'd3}},
    '{1'b0, OP_TAKE,   32'h0000_0000, 16'hffff, 1'b0, '0},
    '{1'b0, OP_TAKE,   32'h0000_0000, 16'h0000, 1'b0, '0},
    '{1'b0, OP_NONE,   32'h0000_0000, 16'h0000, 1'b1, '{1'b0, 32'h0, 6'd0, 7'd1}},
    '{1'b0, OP_CLEAR,  32'hffff_ffff, 16'hffff, 1'b1, '{1'b0, 32'h0, 6'd0, 7'd0}},
    '{1'b0, OP_TAKE,   32'h0000_0000, 16'h8000, 1'b1, '{1'b0, 32'h0, 6'd0, 7'd0}},
    '{1'b0, OP_INSERT, 32'ha5a5_a5a5, 16'h0000, 1'b1, '{1'b1, 32'h0, 6'd0, 7'd1}},
    '{1'b0, OP_INSERT, 32'h5a5a_5a5a, 16'h0000, 1'b1, '{1'b1, 32'h0, 6'd1, 7'd2}},
    '{1'b0, OP_TAKE,   32'h0000_0000, 16'h8000, 1'b1, '{1'b1, 32'ha5a5_a5a5, 6'd0, 7'd1}},
    '{1'b1, OP_INSERT, 32'h0000_ffff, 16'h0000, 1'b0, '0},
    '{1'b1, OP_INSERT, 32'hffff_0000, 16'h0000, 1'b0, '0},
    '{1'b1, OP_TAKE,   32'h0000_0000, 16'hffff, 1'b0, '0},
    '{1'b1, OP_TAKE,   32'h0000_0000, 16'hffff, 1'b0, '0},
    '{1'b1, OP_TAKE,   32'h0000_0000, 16'h0000, 1'b0, '0},
    '{1'b1, OP_TAKE,   32'h0000_0000, 16'hffff, 1'b1, '{1'b0, 32'h0, 6'd0, 7'd0}},
    '{1'b0, OP_INSERT, 32'h8000_0001, 16'h0000, 1'b0, '0}
  };

  logic             clk_i          = 1'b0;
  logic             rst_ni         = 1'b0;
  logic             cfg_we_i       = 1'b0;
  logic             cfg_wdata_i    = 1'b0;
  logic             in_valid_i     = 1'b0;
  logic             in_ready_o;
  logic [OP_W-1:0]  operation_i    = OP_NONE;
  logic [HB-1:0]    task_handle_i  = '0;
  logic [RND_W-1:0] random_value_i = '0;
  logic             out_valid_o;
  logic             out_ready_i    = 1'b0;
  logic             success_o;
  logic [HB-1:0]    handle_out_o;
  logic [IDX_W-1:0] slot_index_o;
  logic [CNT_W-1:0] occupancy_o;

  // shadow copy of the pool
  logic [SLOTS-1:0] slot_busy = '0;
  logic [HB-1:0]    slot_word [SLOTS];
  logic [CNT_W-1:0] busy_count = '0;
  logic             lowest_first = 1'b0;

  pool_result_t pending_results [$];
  int unsigned  fail_cnt   = 0;
  bit           idle_on    = 1'b1;
  int unsigned  stall_left = 0;

  slot_task_pool_unit #(
    .SLOTS       (SLOTS),
    .HANDLE_BITS (HB)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .task_handle_i  (task_handle_i),
    .random_value_i (random_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .success_o      (success_o),
    .handle_out_o   (handle_out_o),
    .slot_index_o   (slot_index_o),
    .occupancy_o    (occupancy_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // generous run limit
  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // first busy slot at or above start, -1 if none
  function automatic int lowest_busy(input int start);
    int i;
    int found;
    found = -1;
    for (i = SLOTS - 1; i >= start; i--)
      if (slot_busy[i]) found = i;
    return found;
  endfunction

  // apply one operation to the shadow pool and return its result
  function automatic pool_result_t predict_pool_op(input logic [OP_W-1:0] op,
                                                   input logic [HB-1:0] h,
                                                   input logic [RND_W-1:0] rnd);
    pool_result_t r;
    int i;
    int pick;
    int top;
    int first;
    r = '0;
    case (op)
      OP_INSERT: begin
        pick = -1;
        for (i = SLOTS - 1; i >= 0; i--)
          if (!slot_busy[i]) pick = i;
        if (pick >= 0) begin
          slot_busy[pick] = 1'b1;
          slot_word[pick] = h;
          busy_count      = busy_count + 1'b1;
          r.success       = 1'b1;
          r.slot          = pick[IDX_W-1:0];
        end
      end
      OP_TAKE: begin
        pick = lowest_busy(0);
        // randomized pick skips ahead unless slot 0 holds a handle
        if (!lowest_first && !slot_busy[0]) begin
          top = 0;
          for (i = 1; i < SLOTS; i++)
            if (slot_busy[i]) top = i;
          if (top > 0) begin
            first = lowest_busy((int'(rnd) * top) >> 16);
            if (first >= 0) pick = first;
          end
        end
        if (pick >= 0) begin
          r.handle        = slot_word[pick];
          slot_busy[pick] = 1'b0;
          if (busy_count != 0) busy_count = busy_count - 1'b1;
          r.success       = 1'b1;
          r.slot          = pick[IDX_W-1:0];
        end
      end
      OP_CLEAR: begin
        slot_busy  = '0;
        busy_count = '0;
      end
      default: ;
    endcase
    r.occ = busy_count;
    return r;
  endfunction

  // send one beat; called right after a rising edge, returns at its accept edge
  task automatic push_op(input logic [OP_W-1:0] op, input logic [HB-1:0] h,
                         input logic [RND_W-1:0] rnd, input logic typed,
                         input pool_result_t want);
    pool_result_t guess;
    guess = predict_pool_op(op, h, rnd);
    pending_results.push_back(typed ? want : guess);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    task_handle_i  <= h;
    random_value_i <= rnd;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // mode register write once the pool has gone quiet
  task automatic set_mode(input logic m);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    lowest_first = m;
  endtask

  // result side back-pressure in bursts
  always @(posedge clk_i) begin
    if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      stall_left  <= 0;
      out_ready_i <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left  <= $urandom_range(1, 7);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    pool_result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        fail_cnt++;
      end else begin
        exp_r = pending_results.pop_front();
        if (success_o !== exp_r.success) begin
          $error("success expected %0d got %0d", exp_r.success, success_o);
          fail_cnt++;
        end
        if (handle_out_o !== exp_r.handle) begin
          $error("handle_out expected %h got %h", exp_r.handle, handle_out_o);
          fail_cnt++;
        end
        if (slot_index_o !== exp_r.slot) begin
          $error("slot_index expected %0d got %0d", exp_r.slot, slot_index_o);
          fail_cnt++;
        end
        if (occupancy_o !== exp_r.occ) begin
          $error("occupancy expected %0d got %0d", exp_r.occ, occupancy_o);
          fail_cnt++;
        end
      end
    end
  end

  // stimulus
  initial begin
    int unsigned    sent;
    int unsigned    ph_len;
    int unsigned    ins_pct;
    int unsigned    clr_pct;
    int unsigned    roll;
    int unsigned    k;
    phase_kind_e    kind;
    logic [OP_W-1:0]  op;
    logic [HB-1:0]    h;
    logic [RND_W-1:0] rnd;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_mode(1'b0);

    // directed table
    for (k = 0; k < DIR_N; k++) begin
      if (DIR_ROWS[k].mode != lowest_first) set_mode(DIR_ROWS[k].mode);
      push_op(DIR_ROWS[k].op, DIR_ROWS[k].handle, DIR_ROWS[k].rnd,
              DIR_ROWS[k].typed, DIR_ROWS[k].want);
    end

    // random phases, the first one fills the pool past full
    sent = 0;
    kind = PH_FILL;
    while (sent < 1250) begin
      set_mode(1'($urandom_range(0, 1)));
      ph_len  = (sent == 0) ? 130 : $urandom_range(60, 160);
      ins_pct = (kind == PH_FILL) ? 78 : (kind == PH_DRAIN) ? 20 : 46;
      clr_pct = (kind == PH_FILL) ? 0 : 2;
      for (k = 0; k < ph_len && sent < 1250; k++) begin
        idle_on = (sent < 1100);
        roll = $urandom_range(0, 99);
        if (roll < clr_pct) op = OP_CLEAR;
        else if (roll < clr_pct + 3) op = OP_NONE;
        else if (roll < clr_pct + 3 + ins_pct) op = OP_INSERT;
        else op = OP_TAKE;
        case ($urandom_range(0, 15))
          0:       h = '0;
          1:       h = '1;
          default: h = $urandom;
        endcase
        case ($urandom_range(0, 7))
          0:       rnd = '0;
          1:       rnd = '1;
          default: rnd = RND_W'($urandom);
        endcase
        push_op(op, h, rnd, 1'b0, '0);
        sent++;
      end
      kind = phase_kind_e'($urandom_range(0, 2));
    end

    // drain
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2 * SLOTS + 10) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
